// ===== hw/rtl/jfss_pkg.sv =====
// ----------------------------------------------------------------------------
// jfss_pkg
// shared types and codes for the jpeg frame size scanner
// ----------------------------------------------------------------------------
package jfss_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 16;
    localparam int unsigned StatW  = 2;
    localparam int unsigned HdrW   = 3;
    localparam int unsigned OutW   = 40;   // status + width + height, byte padded

    // marker and signature bytes
    localparam logic [ByteW-1:0] BYTE_FF  = 8'hff;
    localparam logic [ByteW-1:0] MRK_SOI  = 8'hd8;
    localparam logic [ByteW-1:0] MRK_EOI  = 8'hd9;
    localparam logic [ByteW-1:0] MRK_RST0 = 8'hd0;
    localparam logic [ByteW-1:0] MRK_RST7 = 8'hd7;
    localparam logic [ByteW-1:0] MRK_TEM  = 8'h01;
    localparam logic [ByteW-1:0] MRK_SOF0 = 8'hc0;
    localparam logic [ByteW-1:0] MRK_SOF3 = 8'hc3;
    localparam logic [ByteW-1:0] MRK_SOF5 = 8'hc5;
    localparam logic [ByteW-1:0] MRK_SOF7 = 8'hc7;
    localparam logic [ByteW-1:0] MRK_SOF9 = 8'hc9;
    localparam logic [ByteW-1:0] MRK_SOFF = 8'hcf;
    localparam logic [ByteW-1:0] MRK_DHT  = 8'hc4;
    localparam logic [ByteW-1:0] MRK_JPG  = 8'hc8;
    localparam logic [ByteW-1:0] MRK_DAC  = 8'hcc;

    localparam logic [HdrW-1:0]  HDR_FULL = 3'd4;
    localparam logic [WordW-1:0] MIN_SOF_LEN = 16'd7;

    typedef enum logic [StatW-1:0] {
        ST_FOUND = 2'd0,
        ST_BAD   = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    typedef enum logic [10:0] {
        PH_SIG0  = 11'b000_0000_0001,
        PH_SIG1  = 11'b000_0000_0010,
        PH_SIG2  = 11'b000_0000_0100,
        PH_HUNT  = 11'b000_0000_1000,
        PH_RUN   = 11'b000_0001_0000,
        PH_LENHI = 11'b000_0010_0000,
        PH_LENLO = 11'b000_0100_0000,
        PH_BODY  = 11'b000_1000_0000,
        PH_BAD   = 11'b001_0000_0000,
        PH_DEAD  = 11'b010_0000_0000,
        PH_DONE  = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [HdrW-1:0]  hdr_cnt;
        logic [WordW-1:0] seg_len;
        logic [WordW-1:0] body_cnt;
        logic             is_sof;
        logic [WordW-1:0] width;
        logic [WordW-1:0] height;
    } t_scan_state;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [WordW-1:0] width;
        logic [WordW-1:0] height;
    } t_scan_result;

    localparam t_scan_state SCAN_RESET = '{
        phase:    PH_SIG0,
        hdr_cnt:  '0,
        seg_len:  '0,
        body_cnt: '0,
        is_sof:   1'b0,
        width:    '0,
        height:   '0
    };

endpackage

// ===== hw/rtl/jpeg_frame_size_scanner.sv =====
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// scans a jpeg byte stream for the frame header and reports width and height
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register, and its result then
//   waits in the result register until the output side takes it
// throughput: one byte per cycle while the output side keeps tready high;
//   the only stall is a held result blocking the input register
// reset: synchronous active-low i_rst_n empties both registers and returns
//   the scan state to the signature phase; the last byte of a file also resets the scan state
module jpeg_frame_size_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [1:0] status, [17:2] frame_width,
                                     // [33:18] frame_height, [39:34] zero
);
    import jfss_pkg::*;

    // input register
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;

    // scan state, advanced once per registered byte
    t_scan_state r_state;
    t_scan_state n_state;
    t_scan_result step_res;

    // result register
    logic             r_out_valid;
    t_status          r_out_status;
    logic [WordW-1:0] r_out_width;
    logic [WordW-1:0] r_out_height;

    logic out_free;
    logic advance;

    // the registered byte may move on whenever the result slot is empty or
    // being drained this cycle, whether or not it makes a result
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || advance;

    jfss_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_res.valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out_status <= step_res.status;
            r_out_width  <= step_res.width;
            r_out_height <= step_res.height;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_height, r_out_width, r_out_status};

endmodule

// ===== hw/rtl/jfss_step.sv =====
// ----------------------------------------------------------------------------
// jfss_step
// next-state and result logic for one byte of the scanner
// ----------------------------------------------------------------------------
module jfss_step (
    input  jfss_pkg::t_scan_state  i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output jfss_pkg::t_scan_state  o_state,
    output jfss_pkg::t_scan_result o_result
);
    import jfss_pkg::*;

    logic             is_standalone;
    logic             is_frame;
    logic [WordW-1:0] body_inc;
    logic [WordW:0]   body_end;
    logic             found;
    logic             bad;
    t_scan_state      upd;

    assign is_standalone = (i_byte == MRK_SOI) || (i_byte == MRK_EOI) ||
                           ((i_byte >= MRK_RST0) && (i_byte <= MRK_RST7)) ||
                           (i_byte == MRK_TEM);
    // c0..cf except c4, c8 and cc
    assign is_frame = (i_byte >= MRK_SOF0) && (i_byte <= MRK_SOFF) &&
                      (i_byte != MRK_DHT) && (i_byte != MRK_JPG) && (i_byte != MRK_DAC);

    assign body_inc = i_state.body_cnt + 16'd1;
    assign body_end = {1'b0, body_inc} + 17'd2;

    always_comb begin
        upd   = i_state;
        found = 1'b0;
        if (i_state.hdr_cnt < HDR_FULL) begin
            upd.hdr_cnt = i_state.hdr_cnt + 3'd1;
        end
        unique case (i_state.phase)
            PH_SIG0:  upd.phase = (i_byte == BYTE_FF) ? PH_SIG1 : PH_BAD;
            PH_SIG1:  upd.phase = (i_byte == MRK_SOI) ? PH_SIG2 : PH_BAD;
            PH_SIG2:  upd.phase = (i_byte == BYTE_FF) ? PH_RUN  : PH_BAD;
            PH_HUNT: begin
                if (i_byte == BYTE_FF) upd.phase = PH_RUN;
            end
            PH_RUN: begin
                if (i_byte != BYTE_FF) begin
                    if (is_standalone) begin
                        upd.phase = PH_HUNT;
                    end else begin
                        upd.is_sof = is_frame;
                        upd.phase  = PH_LENHI;
                    end
                end
            end
            PH_LENHI: begin
                upd.seg_len = {i_byte, 8'h00};
                upd.phase   = PH_LENLO;
            end
            PH_LENLO: begin
                upd.seg_len  = {i_state.seg_len[15:8], i_byte};
                upd.body_cnt = '0;
                upd.width    = '0;
                upd.height   = '0;
                if (upd.seg_len < 16'd2)       upd.phase = PH_DEAD;
                else if (upd.seg_len == 16'd2) upd.phase = PH_HUNT;
                else                           upd.phase = PH_BODY;
            end
            PH_BODY: begin
                if (i_state.is_sof) begin
                    if (i_state.body_cnt == 16'd1 || i_state.body_cnt == 16'd2) begin
                        upd.height = {i_state.height[7:0], i_byte};
                    end else if (i_state.body_cnt == 16'd3 || i_state.body_cnt == 16'd4) begin
                        upd.width = {i_state.width[7:0], i_byte};
                    end
                end
                upd.body_cnt = body_inc;
                if (body_end >= {1'b0, i_state.seg_len}) begin
                    if (i_state.is_sof && (i_state.seg_len >= MIN_SOF_LEN)) begin
                        found     = 1'b1;
                        upd.phase = PH_DONE;
                    end else begin
                        upd.phase = PH_HUNT;
                    end
                end
            end
            PH_BAD, PH_DONE: upd.phase = i_state.phase;
            default:         upd.phase = PH_DEAD;
        endcase
    end

    assign bad = (upd.phase == PH_SIG0) || (upd.phase == PH_SIG1) ||
                 (upd.phase == PH_SIG2) || (upd.phase == PH_BAD) ||
                 (upd.hdr_cnt < HDR_FULL);

    always_comb begin
        o_result.valid  = found || (i_last && (upd.phase != PH_DONE));
        o_result.status = found ? ST_FOUND : (bad ? ST_BAD : ST_NONE);
        o_result.width  = found ? upd.width  : '0;
        o_result.height = found ? upd.height : '0;
        o_state         = i_last ? SCAN_RESET : upd;
    end

endmodule
